/* hw/rtl/gray_pixel_word_packer_macros.svh */
// assertion macros for the gray pixel word packer checker
`ifndef GRAY_PIXEL_WORD_PACKER_MACROS_SVH
`define GRAY_PIXEL_WORD_PACKER_MACROS_SVH

// same-cycle implication, ignored while in reset
`define GPWP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, ignored while in reset
`define GPWP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, also checked across reset
`define GPWP_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/gpwp_pkg.sv */
// shared types, constants and helper functions for the gray pixel word packer
package gpwp_pkg;

  localparam int WordBits = 32;
  localparam int FillW    = 6;
  localparam int DepthW   = 6;
  localparam int ColsW    = 15;
  localparam int PadW     = 5;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 15;

  localparam logic [CfgIdxW-1:0] RegDepth   = 1'b0;
  localparam logic [CfgIdxW-1:0] RegColumns = 1'b1;

  localparam logic [DepthW-1:0] DepthRst = 6'd8;
  localparam logic [ColsW-1:0]  ColsRst  = 15'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic step_pixel;
    logic step_pad;
    logic flush;
    logic out_load;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic emits;
    logic row_end;
    logic pad_zero;
    logic pad_last;
    logic fill_nz;
  } stat_t;

  function automatic logic [FillW-1:0] slot_width(input logic [DepthW-1:0] d);
    logic [FillW-1:0] w;
    if (d <= 6'd1) w = 6'd1;
    else if (d == 6'd2) w = 6'd2;
    else if (d <= 6'd4) w = 6'd4;
    else if (d <= 6'd8) w = 6'd8;
    else if (d <= 6'd16) w = 6'd16;
    else w = 6'd32;
    return w;
  endfunction

  function automatic logic [WordBits-1:0] slot_mask(input logic [DepthW-1:0] d);
    logic [WordBits-1:0] m;
    if (d <= 6'd1) m = 32'h0000_0001;
    else if (d == 6'd2) m = 32'h0000_0003;
    else if (d <= 6'd4) m = 32'h0000_000F;
    else if (d <= 6'd8) m = 32'h0000_00FF;
    else if (d <= 6'd16) m = 32'h0000_FFFF;
    else m = 32'hFFFF_FFFF;
    return m;
  endfunction

endpackage

/* hw/rtl/gpwp_dpath.sv */
// datapath: config registers, accumulator, fill and column counters, output register
module gpwp_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [gpwp_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [gpwp_pkg::CfgDataW-1:0]     cfg_data,
  input  logic [gpwp_pkg::WordBits-1:0]     in_pixel,
  input  gpwp_pkg::cmd_t                    cmd,
  output gpwp_pkg::stat_t                   stat,
  output logic [gpwp_pkg::WordBits-1:0]     out_word,
  output logic                              out_last
);

  logic [gpwp_pkg::DepthW-1:0]   depth_r;
  logic [gpwp_pkg::ColsW-1:0]    cols_r;
  logic [gpwp_pkg::WordBits-1:0] acc_r;
  logic [gpwp_pkg::FillW-1:0]    fill_r;
  logic [gpwp_pkg::ColsW-1:0]    col_r;
  logic [gpwp_pkg::PadW-1:0]     pad_cnt_r;
  logic [gpwp_pkg::WordBits-1:0] word_r;
  logic                          last_r;

  logic [gpwp_pkg::FillW-1:0]    width;
  logic [gpwp_pkg::WordBits-1:0] value;
  logic [gpwp_pkg::WordBits-1:0] acc_ins;
  logic [gpwp_pkg::FillW:0]      fill_sum;
  logic                          emits;
  logic [gpwp_pkg::WordBits-1:0] acc_after;
  logic [gpwp_pkg::FillW-1:0]    fill_after;
  logic [gpwp_pkg::ColsW-1:0]    cols_eff;
  logic [gpwp_pkg::ColsW:0]      count;
  logic                          row_end;
  logic [gpwp_pkg::PadW-1:0]     pad_init;

  always_comb begin
    width      = gpwp_pkg::slot_width(depth_r);
    value      = cmd.step_pixel ? (in_pixel & gpwp_pkg::slot_mask(depth_r)) : '0;
    acc_ins    = acc_r | (value << fill_r[gpwp_pkg::PadW-1:0]);
    fill_sum   = {1'b0, fill_r} + {1'b0, width};
    emits      = fill_sum >= 7'(gpwp_pkg::WordBits);
    acc_after  = emits ? '0 : acc_ins;
    fill_after = emits ? '0 : fill_sum[gpwp_pkg::FillW-1:0];
    cols_eff   = (cols_r == '0) ? 15'd1 : cols_r;
    count      = {1'b0, col_r} + 16'd1;
    row_end    = count >= {1'b0, cols_eff};
    pad_init   = 5'd0 - count[gpwp_pkg::PadW-1:0];
  end

  assign stat.emits    = emits;
  assign stat.row_end  = row_end;
  assign stat.pad_zero = (count[gpwp_pkg::PadW-1:0] == '0);
  assign stat.pad_last = (pad_cnt_r == 5'd1);
  assign stat.fill_nz  = (fill_after != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= gpwp_pkg::DepthRst;
      cols_r  <= gpwp_pkg::ColsRst;
      acc_r   <= '0;
      fill_r  <= '0;
      col_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          gpwp_pkg::RegDepth:   depth_r <= cfg_data[gpwp_pkg::DepthW-1:0];
          gpwp_pkg::RegColumns: cols_r  <= cfg_data[gpwp_pkg::ColsW-1:0];
          default: ;
        endcase
      end
      if (cmd.step_pixel || cmd.step_pad) begin
        acc_r  <= acc_after;
        fill_r <= fill_after;
      end else if (cmd.flush) begin
        acc_r  <= '0;
        fill_r <= '0;
      end
      if (cmd.step_pixel) begin
        col_r <= row_end ? '0 : count[gpwp_pkg::ColsW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_pixel) begin
      pad_cnt_r <= pad_init;
    end else if (cmd.step_pad) begin
      pad_cnt_r <= pad_cnt_r - 5'd1;
    end
    if (cmd.out_load) begin
      word_r <= cmd.flush ? ~acc_r : ~acc_ins;
      last_r <= cmd.out_last;
    end
  end

  assign out_word = word_r;
  assign out_last = last_r;

endmodule

/* hw/rtl/gpwp_ctrl.sv */
// controller: pixel, row padding and flush sequencing plus output valid
module gpwp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  gpwp_pkg::stat_t stat,
  output gpwp_pkg::cmd_t  cmd
);

  gpwp_pkg::state_t state_r;
  gpwp_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gpwp_pkg::ST_IDLE: begin
        if (in_valid && out_free && stat.row_end) begin
          if (!stat.pad_zero) state_nxt = gpwp_pkg::ST_PAD;
          else if (stat.fill_nz) state_nxt = gpwp_pkg::ST_FLUSH;
        end
      end
      gpwp_pkg::ST_PAD: begin
        if (out_free && stat.pad_last) begin
          state_nxt = stat.fill_nz ? gpwp_pkg::ST_FLUSH : gpwp_pkg::ST_IDLE;
        end
      end
      gpwp_pkg::ST_FLUSH: begin
        if (out_free) state_nxt = gpwp_pkg::ST_IDLE;
      end
      default: state_nxt = gpwp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      gpwp_pkg::ST_IDLE: begin
        in_ready       = out_free;
        cmd.step_pixel = in_valid && out_free;
        cmd.out_load   = cmd.step_pixel && stat.emits;
        cmd.out_last   = !(stat.row_end && !stat.pad_zero);
      end
      gpwp_pkg::ST_PAD: begin
        cmd.step_pad = out_free;
        cmd.out_load = out_free && stat.emits;
        cmd.out_last = stat.pad_last;
      end
      gpwp_pkg::ST_FLUSH: begin
        cmd.flush    = out_free;
        cmd.out_load = out_free;
        cmd.out_last = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gpwp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* hw/rtl/gray_pixel_word_packer.sv */
// top level of the gray pixel word packer
//
// in_*: one gray pixel per beat, valid/ready. Only the low slot-width bits
// of in_pixel are used; slot width is 1, 2, 4, 8, 16 or 32 from cfg depth.
// out_*: one packed 32-bit word per beat, bit-inverted, first pixel in the
// low bits; out_last marks the final word caused by one input beat.
// cfg_*: write-only registers, index 0 depth, index 1 columns. The user must
// write them only while the block is idle; the block does not enforce this.
// Throughput: one pixel per cycle while the output side keeps up. A pixel
// that fills a word puts it in the output register at the accepting edge,
// so it shows on out_* in the next cycle. At the end of a row the controller
// places up to 31 zero pad slots, one per cycle while the output side keeps
// up, then flushes any partial word left, and takes no pixel meanwhile.
// Reset: synchronous, depth 8, columns 32, empty word, column zero.
// A stalled receiver holds the output register, and every step that could
// emit (new pixel, pad slot, flush) waits until it drains.
module gray_pixel_word_packer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gpwp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [gpwp_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gpwp_pkg::WordBits-1:0] in_pixel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gpwp_pkg::WordBits-1:0] out_word,
  output logic                          out_last
);

  gpwp_pkg::cmd_t  cmd;
  gpwp_pkg::stat_t stat;

  gpwp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gpwp_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_pixel  (in_pixel),
    .cmd       (cmd),
    .stat      (stat),
    .out_word  (out_word),
    .out_last  (out_last)
  );

endmodule

/* hw/rtl/gpwp_checker.sv */
// port-level assertion checker for the gray pixel word packer, with bind
`include "gray_pixel_word_packer_macros.svh"

module gpwp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [gpwp_pkg::WordBits-1:0] out_word,
  input logic                          out_last
);

  // a stalled output beat holds
  `GPWP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word) && $stable(out_last), "output beat changed while stalled")

  // no pixel taken while a word waits on a stalled receiver
  `GPWP_ASSERT_NOW(a_no_take_on_stall, out_valid && !out_ready, !in_ready, "pixel accepted while output stalled")

  // reset empties the output register
  `GPWP_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid, "output valid right after reset")

  // a word appears only after a pixel or during row-end work, never from idle
  `GPWP_ASSERT_NEXT(a_no_spurious, !out_valid && in_ready && !in_valid, !out_valid, "word appeared with no pixel")

endmodule

bind gray_pixel_word_packer gpwp_checker u_gpwp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word),
  .out_last  (out_last)
);
